>>> src/muscle_fiber_stress_top_assert.svh
// Assertion macros for the fibre stress block checker.
// Expects clk and arst_n in the scope of use.
`ifndef MUSCLE_FIBER_STRESS_TOP_ASSERT_SVH
`define MUSCLE_FIBER_STRESS_TOP_ASSERT_SVH

`define MFS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define MFS_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/mfs_pkg.sv
// Shared types and widths for the fibre muscle stress block.
// No dependencies.
package mfs_pkg;

	localparam int QW   = 32;
	localparam int MW   = 18;
	localparam int KW   = 31;
	localparam int FW   = 34;
	localparam int SQW  = 2 * FW;
	localparam int SW   = 72;
	localparam int LW   = 36;
	localparam int DVW  = LW + 2;
	localparam int DW   = 36;
	localparam int KDW  = KW + DW;
	localparam int KLO  = 34;
	localparam int CW   = 34;
	localparam int NC   = 3;
	localparam int XPW  = NC * CW;
	localparam int NW   = XPW + MW;
	localparam int EW   = KDW + DW;
	localparam int ESH  = 33;
	localparam int QB   = 32;
	localparam int NL   = 9;
	localparam int IW   = 8;

	typedef enum logic [IW-1:0] {
		REG_STIFFNESS = 8'd0,
		REG_FIBER_X   = 8'd1,
		REG_FIBER_Y   = 8'd2,
		REG_FIBER_Z   = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [QW-1:0] f_00;
		logic signed [QW-1:0] f_01;
		logic signed [QW-1:0] f_02;
		logic signed [QW-1:0] f_10;
		logic signed [QW-1:0] f_11;
		logic signed [QW-1:0] f_12;
		logic signed [QW-1:0] f_20;
		logic signed [QW-1:0] f_21;
		logic signed [QW-1:0] f_22;
		logic signed [QW-1:0] activation;
	} in_beat_t;

	typedef struct packed {
		logic signed [QW-1:0] p_00;
		logic signed [QW-1:0] p_01;
		logic signed [QW-1:0] p_02;
		logic signed [QW-1:0] p_10;
		logic signed [QW-1:0] p_11;
		logic signed [QW-1:0] p_12;
		logic signed [QW-1:0] p_20;
		logic signed [QW-1:0] p_21;
		logic signed [QW-1:0] p_22;
		logic [QW-1:0]        energy;
		logic                 degenerate;
	} out_beat_t;

	typedef struct packed {
		logic [IW-1:0] index;
		logic [QW-1:0] value;
	} cfg_beat_t;

	typedef struct packed {
		logic [2:0][FW-1:0]   fm_mag;
		logic [2:0]           fm_neg;
		logic signed [QW-1:0] act;
	} sq_side_t;

	typedef struct packed {
		logic [NL-1:0] neg;
		logic [NL-1:0] over;
		logic [QW-1:0] energy;
		logic          degen;
	} dv_side_t;

endpackage

>>> src/mfs_if.sv
// Valid/ready channel interfaces for input, result and configuration beats.
// Depends on mfs_pkg.
interface mfs_in_if;
	logic               valid;
	logic               ready;
	mfs_pkg::in_beat_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mfs_out_if;
	logic               valid;
	logic               ready;
	mfs_pkg::out_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mfs_cfg_if;
	logic               valid;
	logic               ready;
	mfs_pkg::cfg_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/mfs_sqrt_cell.sv
// One digit cell of the pipelined square root chain; resolves root bit BIT.
// Depends on mfs_pkg.
module mfs_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  logic [mfs_pkg::SW-1:0]   rem_in,
	input  logic [mfs_pkg::LW-1:0]   root_in,
	input  mfs_pkg::sq_side_t        side_in,
	output logic                     v_out,
	output logic [mfs_pkg::SW-1:0]   rem_out,
	output logic [mfs_pkg::LW-1:0]   root_out,
	output mfs_pkg::sq_side_t        side_out
);
	import mfs_pkg::*;

	logic [SW-1:0] trial;
	logic          take;

	assign trial = (SW'(root_in) << (BIT + 1)) | (SW'(1) << (2 * BIT));
	assign take  = rem_in >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? rem_in - trial : rem_in;
			root_out <= take ? (root_in | (LW'(1) << BIT)) : root_in;
			side_out <= side_in;
		end
	end

endmodule

>>> src/mfs_div_cell.sv
// One restoring division cell; resolves quotient bit BIT for all nine lanes.
// Depends on mfs_pkg.
module mfs_div_cell #(
	parameter int BIT = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   v_in,
	input  logic [mfs_pkg::LW-1:0]                 l_in,
	input  logic [mfs_pkg::NL-1:0][mfs_pkg::NW-1:0] rem_in,
	input  logic [mfs_pkg::NL-1:0][mfs_pkg::QB-1:0] q_in,
	input  mfs_pkg::dv_side_t                      side_in,
	output logic                                   v_out,
	output logic [mfs_pkg::LW-1:0]                 l_out,
	output logic [mfs_pkg::NL-1:0][mfs_pkg::NW-1:0] rem_out,
	output logic [mfs_pkg::NL-1:0][mfs_pkg::QB-1:0] q_out,
	output mfs_pkg::dv_side_t                      side_out
);
	import mfs_pkg::*;

	logic [NW-1:0]          ds;
	logic [NL-1:0][NW-1:0]  rem_nx;
	logic [NL-1:0][QB-1:0]  q_nx;

	assign ds = NW'(l_in) << (QB + BIT);

	always_comb begin
		for (int ln = 0; ln < NL; ln++) begin
			if (rem_in[ln] >= ds) begin
				rem_nx[ln] = rem_in[ln] - ds;
				q_nx[ln]   = q_in[ln] | (QB'(1) << BIT);
			end else begin
				rem_nx[ln] = rem_in[ln];
				q_nx[ln]   = q_in[ln];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_out    <= l_in;
			rem_out  <= rem_nx;
			q_out    <= q_nx;
			side_out <= side_in;
		end
	end

endmodule

>>> src/muscle_fiber_stress_top.sv
// Fibre muscle energy and stress: top level with front end, chains and output buffer.
// Depends on mfs_pkg, mfs_if, mfs_sqrt_cell, mfs_div_cell.
// Fully pipelined: one beat per cycle in and out while the output is not
// stalled. The depth is set by the 36-cell square root chain and the
// 32-cell division chain; the products in between are split into partial
// products over four stages. A stall on the output parks one result in a
// skid register and holds the whole pipeline until it drains. Configuration
// is taken at any time but must only change while the block is empty.
module muscle_fiber_stress_top #(
	parameter int DIM = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	mfs_in_if.sink    in_ch,
	mfs_out_if.source out_ch,
	mfs_cfg_if.sink   cfg
);
	import mfs_pkg::*;

	logic [KW-1:0]        k_q;
	logic signed [MW-1:0] m_q [3];
	logic [MW-1:0]        mmag [3];
	logic [2:0]           mneg;

	logic en;
	logic out_v_q, skid_v_q;
	out_beat_t out_q, skid_q;

	// front end
	logic                 v_s1;
	in_beat_t             f_s1;
	logic signed [QW-1:0] fa [3][3];
	logic                 v_s2;
	logic signed [49:0]   prod_s2 [3][3];
	logic signed [QW-1:0] act_s2;
	logic signed [51:0]   rsum [3];
	logic signed [35:0]   fmv [3];
	logic signed [35:0]   fmn [3];
	logic                 v_s3;
	logic [FW-1:0]        fmag_s3 [3];
	logic [2:0]           fneg_s3;
	logic signed [QW-1:0] act_s3;
	logic                 v_s4;
	logic [SQW-1:0]       sq_s4 [3];
	sq_side_t             side_s4;
	logic                 v_s5;
	logic [SW-1:0]        s_s5;
	sq_side_t             side_s5;

	// square root chain
	logic                 sq_v    [LW+1];
	logic [SW-1:0]        sq_rem  [LW+1];
	logic [LW-1:0]        sq_root [LW+1];
	sq_side_t             sq_side [LW+1];

	// back end
	logic signed [DVW-1:0] dv;
	logic [DVW-1:0]        dabs;
	logic                  v_s6;
	logic [DW-1:0]         dmag_s6;
	logic                  dneg_s6, degen_s6;
	logic [LW-1:0]         l_s6;
	logic [2:0][FW-1:0]    fmag_s6;
	logic [2:0]            fneg_s6;
	logic                  v_s7;
	logic [KDW-1:0]        kd_s7;
	logic [DW-1:0]         dmag_s7;
	logic                  dneg_s7, degen_s7;
	logic [LW-1:0]         l_s7;
	logic [2:0][FW-1:0]    fmag_s7;
	logic [2:0]            fneg_s7;
	logic                  v_s8;
	logic [KLO+FW-1:0]     pl_s8 [3];
	logic [KDW-KLO+FW-1:0] ph_s8 [3];
	logic [KLO+DW-1:0]     el_s8;
	logic [KDW-KLO+DW-1:0] eh_s8;
	logic                  dneg_s8, degen_s8;
	logic [LW-1:0]         l_s8;
	logic [2:0]            fneg_s8;
	logic [EW-1:0]         esum;
	logic                  v_s9;
	logic [XPW-1:0]        x_s9 [3];
	logic [QW-1:0]         en_s9;
	logic                  dneg_s9, degen_s9;
	logic [LW-1:0]         l_s9;
	logic [2:0]            fneg_s9;
	logic                  v_s10;
	logic [CW+MW-1:0]      xp_s10 [3][3][NC];
	logic [QW-1:0]         en_s10;
	logic                  dneg_s10, degen_s10;
	logic [LW-1:0]         l_s10;
	logic [2:0]            fneg_s10;
	logic [NW-1:0]         nsum [3][3];
	logic                  v_s11;
	logic [NL-1:0][NW-1:0] n_s11;
	logic [NL-1:0]         neg_s11;
	logic [QW-1:0]         en_s11;
	logic                  degen_s11;
	logic [LW-1:0]         l_s11;
	logic [NW-1:0]         ovl;
	logic                  v_s12;
	logic [NL-1:0][NW-1:0] n_s12;
	logic [LW-1:0]         l_s12;
	dv_side_t              side_s12;

	// division chain
	logic                  dc_v    [QB+1];
	logic [LW-1:0]         dc_l    [QB+1];
	logic [NL-1:0][NW-1:0] dc_rem  [QB+1];
	logic [NL-1:0][QB-1:0] dc_q    [QB+1];
	dv_side_t              dc_side [QB+1];

	logic [QW-1:0]         pv [3][3];
	logic [QW-1:0]         lim, vsat;
	logic                  ln_neg;
	logic                  v_s13;
	out_beat_t             res_s13;
	out_beat_t             res;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= KW'(65536);
			m_q[0] <= MW'(65536);
			m_q[1] <= '0;
			m_q[2] <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_STIFFNESS: k_q    <= cfg.data.value[KW-1:0];
				REG_FIBER_X:   m_q[0] <= cfg.data.value[MW-1:0];
				REG_FIBER_Y:   m_q[1] <= cfg.data.value[MW-1:0];
				REG_FIBER_Z:   m_q[2] <= cfg.data.value[MW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mneg[j] = m_q[j][MW-1];
			mmag[j] = mneg[j] ? MW'(-m_q[j]) : MW'(m_q[j]);
		end
	end

	assign en          = !skid_v_q;
	assign in_ch.ready = en;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= in_ch.data;
		end
	end

	assign fa[0][0] = f_s1.f_00;
	assign fa[0][1] = f_s1.f_01;
	assign fa[0][2] = f_s1.f_02;
	assign fa[1][0] = f_s1.f_10;
	assign fa[1][1] = f_s1.f_11;
	assign fa[1][2] = f_s1.f_12;
	assign fa[2][0] = f_s1.f_20;
	assign fa[2][1] = f_s1.f_21;
	assign fa[2][2] = f_s1.f_22;

	// stage 2: F*m products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (j < DIM) begin
						prod_s2[i][j] <= fa[i][j] * m_q[j];
					end else begin
						prod_s2[i][j] <= '0;
					end
				end
			end
			act_s2 <= f_s1.activation;
		end
	end

	// stage 3: row sums, floored to Q16.16
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsum[i] = prod_s2[i][0] + prod_s2[i][1] + prod_s2[i][2];
			fmv[i]  = (i < DIM) ? 36'(rsum[i] >>> 16) : '0;
			fmn[i]  = -fmv[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				fmag_s3[i] <= fmv[i][35] ? fmn[i][FW-1:0] : fmv[i][FW-1:0];
				fneg_s3[i] <= fmv[i][35];
			end
			act_s3 <= act_s2;
		end
	end

	// stage 4: squares; stage 5: sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i]          <= fmag_s3[i] * fmag_s3[i];
				side_s4.fm_mag[i] <= fmag_s3[i];
			end
			side_s4.fm_neg <= fneg_s3;
			side_s4.act    <= act_s3;
			s_s5           <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
			side_s5        <= side_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign sq_v[0]    = v_s5;
	assign sq_rem[0]  = s_s5;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s5;

	for (genvar c = 0; c < LW; c++) begin : g_sqrt
		mfs_sqrt_cell #(.BIT(LW - 1 - c)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (sq_v[c]),
			.rem_in   (sq_rem[c]),
			.root_in  (sq_root[c]),
			.side_in  (sq_side[c]),
			.v_out    (sq_v[c+1]),
			.rem_out  (sq_rem[c+1]),
			.root_out (sq_root[c+1]),
			.side_out (sq_side[c+1])
		);
	end

	// stage 6: l - a
	assign dv   = $signed({2'b00, sq_root[LW]}) - DVW'(sq_side[LW].act);
	assign dabs = dv[DVW-1] ? DVW'(-dv) : DVW'(dv);

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s6  <= dabs[DW-1:0];
			dneg_s6  <= dv[DVW-1];
			degen_s6 <= sq_root[LW] == '0;
			l_s6     <= sq_root[LW];
			fmag_s6  <= sq_side[LW].fm_mag;
			fneg_s6  <= sq_side[LW].fm_neg;
		end
	end

	// stage 7: k*|d|
	always_ff @(posedge clk) begin
		if (en) begin
			kd_s7    <= KDW'(k_q) * KDW'(dmag_s6);
			dmag_s7  <= dmag_s6;
			dneg_s7  <= dneg_s6;
			degen_s7 <= degen_s6;
			l_s7     <= l_s6;
			fmag_s7  <= fmag_s6;
			fneg_s7  <= fneg_s6;
		end
	end

	// stage 8: partial products of k|d| with |Fm_i| and |d|
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pl_s8[i] <= kd_s7[KLO-1:0] * fmag_s7[i];
				ph_s8[i] <= kd_s7[KDW-1:KLO] * fmag_s7[i];
			end
			el_s8    <= kd_s7[KLO-1:0] * dmag_s7;
			eh_s8    <= kd_s7[KDW-1:KLO] * dmag_s7;
			dneg_s8  <= dneg_s7;
			degen_s8 <= degen_s7;
			l_s8     <= l_s7;
			fneg_s8  <= fneg_s7;
		end
	end

	// stage 9: recombine; energy saturates here
	assign esum = EW'(el_s8) + (EW'(eh_s8) << KLO);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				x_s9[i] <= XPW'(pl_s8[i]) + (XPW'(ph_s8[i]) << KLO);
			end
			en_s9    <= (|esum[EW-1:ESH+QW]) ? '1 : esum[ESH+QW-1:ESH];
			dneg_s9  <= dneg_s8;
			degen_s9 <= degen_s8;
			l_s9     <= l_s8;
			fneg_s9  <= fneg_s8;
		end
	end

	// stage 10: chunked products with |m_j|
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int c = 0; c < NC; c++) begin
						xp_s10[i][j][c] <= x_s9[i][c*CW +: CW] * mmag[j];
					end
				end
			end
			en_s10    <= en_s9;
			dneg_s10  <= dneg_s9;
			degen_s10 <= degen_s9;
			l_s10     <= l_s9;
			fneg_s10  <= fneg_s9;
		end
	end

	// stage 11: numerators
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				nsum[i][j] = '0;
				for (int c = 0; c < NC; c++) begin
					nsum[i][j] = nsum[i][j] + (NW'(xp_s10[i][j][c]) << (c * CW));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					n_s11[i*3+j]   <= nsum[i][j];
					neg_s11[i*3+j] <= dneg_s10 ^ fneg_s10[i] ^ mneg[j];
				end
			end
			en_s11    <= en_s10;
			degen_s11 <= degen_s10;
			l_s11     <= l_s10;
		end
	end

	// stage 12: quotient overflow check before the division chain
	assign ovl = NW'(l_s11) << (2 * QB);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ln = 0; ln < NL; ln++) begin
				side_s12.over[ln] <= n_s11[ln] >= ovl;
			end
			n_s12           <= n_s11;
			l_s12           <= l_s11;
			side_s12.neg    <= neg_s11;
			side_s12.energy <= en_s11;
			side_s12.degen  <= degen_s11;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s6  <= sq_v[LW];
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	assign dc_v[0]    = v_s12;
	assign dc_l[0]    = l_s12;
	assign dc_rem[0]  = n_s12;
	assign dc_q[0]    = '0;
	assign dc_side[0] = side_s12;

	for (genvar c = 0; c < QB; c++) begin : g_div
		mfs_div_cell #(.BIT(QB - 1 - c)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (dc_v[c]),
			.l_in     (dc_l[c]),
			.rem_in   (dc_rem[c]),
			.q_in     (dc_q[c]),
			.side_in  (dc_side[c]),
			.v_out    (dc_v[c+1]),
			.l_out    (dc_l[c+1]),
			.rem_out  (dc_rem[c+1]),
			.q_out    (dc_q[c+1]),
			.side_out (dc_side[c+1])
		);
	end

	// stage 13: saturate, sign, mask
	always_comb begin
		lim    = '0;
		vsat   = '0;
		ln_neg = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ln_neg = dc_side[QB].neg[i*3+j];
				lim    = ln_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
				vsat   = (dc_side[QB].over[i*3+j] || dc_q[QB][i*3+j] > lim) ?
					lim : dc_q[QB][i*3+j];
				if (dc_side[QB].degen || i >= DIM || j >= DIM) begin
					pv[i][j] = '0;
				end else begin
					pv[i][j] = ln_neg ? -vsat : vsat;
				end
			end
		end
		res.p_00       = pv[0][0];
		res.p_01       = pv[0][1];
		res.p_02       = pv[0][2];
		res.p_10       = pv[1][0];
		res.p_11       = pv[1][1];
		res.p_12       = pv[1][2];
		res.p_20       = pv[2][0];
		res.p_21       = pv[2][1];
		res.p_22       = pv[2][2];
		res.energy     = dc_side[QB].energy;
		res.degenerate = dc_side[QB].degen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s13 <= dc_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s13 <= res;
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en && v_s13) begin
			if (!out_v_q || out_ch.ready) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_ch.ready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s13) begin
			if (!out_v_q || out_ch.ready) begin
				out_q <= res_s13;
			end else begin
				skid_q <= res_s13;
			end
		end else if (out_ch.ready && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

endmodule

>>> src/mfs_checker.sv
// Port-level checker for the fibre stress block, bound to the top level.
// Depends on mfs_pkg and muscle_fiber_stress_top_assert.svh.
`include "muscle_fiber_stress_top_assert.svh"

module mfs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input mfs_pkg::out_beat_t out_data
);
	import mfs_pkg::*;

	logic p_zero;

	assign p_zero = out_data.p_00 == '0 && out_data.p_01 == '0 && out_data.p_02 == '0 &&
		out_data.p_10 == '0 && out_data.p_11 == '0 && out_data.p_12 == '0 &&
		out_data.p_20 == '0 && out_data.p_21 == '0 && out_data.p_22 == '0;

	`MFS_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
	`MFS_CHECK(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "stalled beat changed")
	`MFS_CHECK_IMP(a_degen_zero, out_valid && out_data.degenerate, p_zero, "degenerate stress not zero")
	`MFS_CHECK_IMP(a_ready_fall, $fell(in_ready), $past(out_valid && !out_ready), "input stalled without output stall")

endmodule

bind muscle_fiber_stress_top mfs_checker u_mfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
